// ----- design/fixed_forest_classifier_top_defines.svh -----
// ----------------------------------------------------------------------------
// fixed_forest_classifier_top_defines
// assertion macros used by the classifier top module
// ----------------------------------------------------------------------------
`ifndef FIXED_FOREST_CLASSIFIER_TOP_DEFINES_SVH
`define FIXED_FOREST_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffc check failed");

// next-cycle implication, checked outside reset
`define FFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffc check failed");

`endif

// ----- design/ffc_pkg.sv -----
// ----------------------------------------------------------------------------
// ffc_pkg
// classes, thresholds and tree functions of the fixed forest classifier
// ----------------------------------------------------------------------------
package ffc_pkg;

  localparam int NumTrees  = 10;
  localparam int FeatW     = 12;
  localparam int CountW    = 4;
  localparam int TreeIdxW  = $clog2(NumTrees);
  localparam int VotesW    = 2 * NumTrees;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 40;

  typedef enum logic [1:0] {
    ClassZero = 2'd0,
    ClassOne  = 2'd1,
    ClassTwo  = 2'd2
  } class_t;

  typedef logic [FeatW-1:0] feat_t;

  // thresholds in hundredths
  localparam feat_t Thr80  = 12'd80;
  localparam feat_t Thr125 = 12'd125;
  localparam feat_t Thr155 = 12'd155;
  localparam feat_t Thr165 = 12'd165;
  localparam feat_t Thr170 = 12'd170;
  localparam feat_t Thr180 = 12'd180;
  localparam feat_t Thr225 = 12'd225;
  localparam feat_t Thr235 = 12'd235;
  localparam feat_t Thr245 = 12'd245;
  localparam feat_t Thr255 = 12'd255;
  localparam feat_t Thr260 = 12'd260;
  localparam feat_t Thr265 = 12'd265;
  localparam feat_t Thr275 = 12'd275;
  localparam feat_t Thr285 = 12'd285;
  localparam feat_t Thr290 = 12'd290;
  localparam feat_t Thr295 = 12'd295;
  localparam feat_t Thr315 = 12'd315;
  localparam feat_t Thr475 = 12'd475;
  localparam feat_t Thr485 = 12'd485;
  localparam feat_t Thr490 = 12'd490;
  localparam feat_t Thr495 = 12'd495;
  localparam feat_t Thr500 = 12'd500;
  localparam feat_t Thr545 = 12'd545;
  localparam feat_t Thr555 = 12'd555;
  localparam feat_t Thr605 = 12'd605;
  localparam feat_t Thr620 = 12'd620;
  localparam feat_t Thr635 = 12'd635;
  localparam feat_t Thr650 = 12'd650;
  localparam feat_t Thr685 = 12'd685;

  function automatic class_t tree_class(input logic [TreeIdxW-1:0] k, input feat_t f1,
                                        input feat_t f2, input feat_t f3, input feat_t f4);
    class_t c;
    case (k)
      4'd0: begin
        if (f4 <= Thr80) c = ClassZero;
        else if (f3 <= Thr495) c = (f4 <= Thr170) ? ClassOne : ClassTwo;
        else c = ClassTwo;
      end
      4'd1: begin
        if (f4 <= Thr80) c = ClassZero;
        else if (f4 > Thr170) c = ClassTwo;
        else if (f3 <= Thr495) c = ClassOne;
        else if (f2 <= Thr265) c = ClassTwo;
        else c = (f2 <= Thr275) ? ClassOne : ClassTwo;
      end
      4'd2: begin
        if (f1 <= Thr555) c = (f4 <= Thr80) ? ClassZero : ClassOne;
        else if (f3 <= Thr475) c = ClassZero;
        else if (f4 <= Thr165) c = (f2 <= Thr295) ? ClassTwo : ClassOne;
        else c = ClassTwo;
      end
      4'd3: begin
        if (f1 <= Thr555) c = (f2 <= Thr285) ? ClassOne : ClassZero;
        else if (f2 <= Thr265) begin
          if (f2 <= Thr235) c = (f4 <= Thr125) ? ClassOne : ClassTwo;
          else c = ClassTwo;
        end else c = (f4 <= Thr125) ? ClassOne : ClassTwo;
      end
      4'd4: begin
        if (f4 <= Thr80) c = ClassZero;
        else if (f4 > Thr170) c = ClassTwo;
        else if (f3 <= Thr495) c = ClassOne;
        else c = (f4 <= Thr155) ? ClassTwo : ClassOne;
      end
      4'd5: begin
        if (f4 <= Thr80) c = ClassZero;
        else if (f4 <= Thr475) c = ClassOne;
        else if (f2 <= Thr275) begin
          if (f4 > Thr170) c = ClassTwo;
          else if (f1 <= Thr605) c = (f2 <= Thr245) ? ClassTwo : ClassOne;
          else c = ClassTwo;
        end else if (f1 <= Thr605) c = (f2 <= Thr245) ? ClassTwo : ClassOne;
        else c = ClassTwo;
      end
      4'd6: begin
        if (f4 > Thr170) c = ClassTwo;
        else if (f3 <= Thr260) c = ClassZero;
        else if (f2 <= Thr225) c = (f4 <= Thr125) ? ClassOne : ClassTwo;
        else if (f1 <= Thr620) c = ClassOne;
        else if (f1 <= Thr635) c = (f3 <= Thr490) ? ClassOne : ClassTwo;
        else c = ClassOne;
      end
      4'd7: begin
        if (f3 <= Thr475) c = (f3 <= Thr260) ? ClassZero : ClassOne;
        else if (f3 <= Thr485) begin
          if (f2 <= Thr290) c = (f1 <= Thr650) ? ClassTwo : ClassOne;
          else c = ClassTwo;
        end else c = ClassTwo;
      end
      4'd8: begin
        if (f4 > Thr170) c = ClassTwo;
        else if (f1 <= Thr545) c = (f3 <= Thr260) ? ClassZero : ClassOne;
        else if (f3 <= Thr255) c = ClassZero;
        else if (f2 <= Thr225) c = ClassTwo;
        else if (f3 <= Thr500) c = ClassOne;
        else c = (f1 <= Thr650) ? ClassOne : ClassTwo;
      end
      default: begin
        if (f3 <= Thr260) c = ClassZero;
        else if (f3 <= Thr475) c = ClassOne;
        else if (f2 <= Thr275) c = (f4 <= Thr170) ? ClassOne : ClassTwo;
        else if (f1 <= Thr685) c = ClassOne;
        else if (f2 <= Thr315) c = (f4 <= Thr180) ? ClassOne : ClassTwo;
        else c = ClassTwo;
      end
    endcase
    return c;
  endfunction

  // population count of the per-tree match flags, split in two halves
  function automatic logic [CountW-1:0] count_flags(input logic [NumTrees-1:0] flags);
    logic [CountW-1:0] lo;
    logic [CountW-1:0] hi;
    lo = '0;
    hi = '0;
    for (int i = 0; i < NumTrees / 2; i++) begin
      lo = lo + CountW'(flags[i]);
      hi = hi + CountW'(flags[i + NumTrees / 2]);
    end
    return lo + hi;
  endfunction

endpackage

// ----- design/fixed_forest_classifier_top.sv -----
// an accepted item's features are registered in stage one, its result in stage two
// throughput: one item per cycle while the output is not stalled, stage one holds the features, stage two the result
// the ten trees, the vote counts and the winner pick sit between the two stages
// s_axis_tready drops only while both stages are full and the output is stalled
// reset clears both stage valid flags; the data registers are not reset
// ----------------------------------------------------------------------------
// fixed_forest_classifier_top
// ten fixed decision trees with a majority vote over a four-feature sample
// ----------------------------------------------------------------------------
`include "fixed_forest_classifier_top_defines.svh"

module fixed_forest_classifier_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sepal_length, sepal_width, petal_length, petal_width (12 bits each)
  input  logic [ffc_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // predicted_class (2), votes_class_zero (4), votes_class_one (4),
  // votes_class_two (4), tree_votes (20), zero fill (6)
  output logic [ffc_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int CW = ffc_pkg::CountW;
  localparam int NT = ffc_pkg::NumTrees;

  logic           s1_valid;
  ffc_pkg::feat_t f1;
  ffc_pkg::feat_t f2;
  ffc_pkg::feat_t f3;
  ffc_pkg::feat_t f4;

  logic                          out_valid;
  ffc_pkg::class_t               predicted_class;
  logic [CW-1:0]                 votes_class_zero;
  logic [CW-1:0]                 votes_class_one;
  logic [CW-1:0]                 votes_class_two;
  logic [ffc_pkg::VotesW-1:0]    tree_votes;

  ffc_pkg::class_t               tree_cls [NT];
  logic [NT-1:0]                 is_zero;
  logic [NT-1:0]                 is_one;
  logic [NT-1:0]                 is_two;
  logic [ffc_pkg::VotesW-1:0]    tree_votes_next;
  logic [CW-1:0]                 cnt0_next;
  logic [CW-1:0]                 cnt1_next;
  logic [CW-1:0]                 cnt2_next;
  ffc_pkg::class_t               predicted_class_next;

  logic out_adv;
  logic s1_adv;

  assign out_adv       = !out_valid || m_axis_tready;
  assign s1_adv        = !s1_valid || out_adv;
  assign s_axis_tready = s1_adv;
  assign m_axis_tvalid = out_valid;

  // stage one: feature register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s1_adv && s_axis_tvalid) begin
      f1 <= s_axis_tdata[11:0];
      f2 <= s_axis_tdata[23:12];
      f3 <= s_axis_tdata[35:24];
      f4 <= s_axis_tdata[47:36];
    end
  end

  // tree evaluation and vote
  always_comb begin
    tree_votes_next = '0;
    for (int k = 0; k < NT; k++) begin
      tree_cls[k] = ffc_pkg::tree_class(ffc_pkg::TreeIdxW'(k), f1, f2, f3, f4);
      is_zero[k]  = (tree_cls[k] == ffc_pkg::ClassZero);
      is_one[k]   = (tree_cls[k] == ffc_pkg::ClassOne);
      is_two[k]   = (tree_cls[k] == ffc_pkg::ClassTwo);
      tree_votes_next[2*k +: 2] = tree_cls[k];
    end
    cnt0_next = ffc_pkg::count_flags(is_zero);
    cnt1_next = ffc_pkg::count_flags(is_one);
    cnt2_next = ffc_pkg::count_flags(is_two);
    // ties favor the lower class
    if (cnt0_next >= cnt1_next && cnt0_next >= cnt2_next) begin
      predicted_class_next = ffc_pkg::ClassZero;
    end else if (cnt1_next >= cnt2_next) begin
      predicted_class_next = ffc_pkg::ClassOne;
    end else begin
      predicted_class_next = ffc_pkg::ClassTwo;
    end
  end

  // stage two: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
    if (out_adv && s1_valid) begin
      predicted_class  <= predicted_class_next;
      votes_class_zero <= cnt0_next;
      votes_class_one  <= cnt1_next;
      votes_class_two  <= cnt2_next;
      tree_votes       <= tree_votes_next;
    end
  end

  assign m_axis_tdata = {6'b0, tree_votes, votes_class_two, votes_class_one,
                         votes_class_zero, predicted_class};

  `FFC_ASSERT_NOW(a_vote_total, clk, rst, out_valid,
    ({1'b0, votes_class_zero} + {1'b0, votes_class_one} + {1'b0, votes_class_two})
      == (CW+1)'(NT))
  `FFC_ASSERT_NOW(a_winner_max, clk, rst, out_valid && predicted_class == ffc_pkg::ClassTwo,
    votes_class_two > votes_class_zero && votes_class_two > votes_class_one)
  `FFC_ASSERT_NOW(a_tie_rule, clk, rst, out_valid && predicted_class == ffc_pkg::ClassOne,
    votes_class_one > votes_class_zero && votes_class_one >= votes_class_two)
  `FFC_ASSERT_NEXT(a_result_follows, clk, rst, s1_valid && out_adv, out_valid)

endmodule
